FILE: rtl/core/jsu_pkg.sv
package jsu_pkg;

  // decoder modes, one-hot
  typedef enum logic [3:0] {
    MODE_PLAIN = 4'b0001,
    MODE_ESC   = 4'b0010,
    MODE_HEX   = 4'b0100,
    MODE_UTF8  = 4'b1000
  } mode_e;

  localparam int unsigned NUM_UNITS = 4;
  localparam int unsigned UNIT_W    = 16;

  // one input byte's worth of code units
  typedef struct packed {
    logic [1:0]                         last_idx;
    logic                               eos;
    logic [NUM_UNITS-1:0][UNIT_W-1:0]   units;
  } burst_t;

  // utf-16 constants
  localparam logic [15:0] REPL_CHAR  = 16'hFFFD;
  localparam logic [15:0] HI_SURR    = 16'hD800;
  localparam logic [15:0] LO_SURR    = 16'hDC00;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;
  localparam logic [20:0] BMP_MAX    = 21'h0FFFF;

  // ascii codes used by the escape decoder
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_N      = 8'h6E;
  localparam logic [7:0] CHAR_T      = 8'h74;
  localparam logic [7:0] CHAR_R      = 8'h72;
  localparam logic [7:0] CHAR_B      = 8'h62;
  localparam logic [7:0] CHAR_F      = 8'h66;
  localparam logic [7:0] CHAR_U      = 8'h75;
  localparam logic [7:0] CHAR_0      = 8'h30;
  localparam logic [7:0] CHAR_9      = 8'h39;
  localparam logic [7:0] CHAR_LA     = 8'h61;
  localparam logic [7:0] CHAR_LF     = 8'h66;
  localparam logic [7:0] CHAR_UA     = 8'h41;
  localparam logic [7:0] CHAR_UF     = 8'h46;

  // control codes that escapes resolve to
  localparam logic [15:0] CODE_LF    = 16'h000A;
  localparam logic [15:0] CODE_TAB   = 16'h0009;
  localparam logic [15:0] CODE_CR    = 16'h000D;
  localparam logic [15:0] CODE_BS    = 16'h0008;
  localparam logic [15:0] CODE_FF    = 16'h000C;

endpackage

FILE: rtl/core/json_string_utf8_to_utf16.sv
// JSON string body decoder, raw bytes in, UTF-16 code units out.
// Input channel: one byte per word (data_byte_i, end_of_string_i) on
// in_valid_i / in_ready_o; mark the final byte of each string with
// end_of_string_i. Output channel: one code unit per word on
// out_valid_o / out_ready_i, with run_last_o on the last unit a byte
// produced and string_last_o on the final unit of the string.
// The front decoder takes one byte per cycle and writes the 0 to 4 units
// it produces as one entry of a small queue (FifoDepth entries). The back
// end drains the queue one unit per cycle into the output register when
// the receiver is not stalling. With the output register free, the first
// unit of a byte passes through the queue and then the output register.
// Throughput: one byte per cycle while the queue has room; the output side
// moves one unit per cycle unless stalled, so a run of multi-unit bytes
// fills the queue and then input rate follows output rate.
// A stalled receiver holds the output word; the queue keeps taking bytes
// until it is full, then in_ready_o drops. Reset clears decoder state,
// the queue and the output valid; the block is ready right after reset.
module json_string_utf8_to_utf16 #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_string_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_unit_o,
  output logic        run_last_o,
  output logic        string_last_o
);

  logic            push;
  jsu_pkg::burst_t push_data;
  logic            full;
  logic            pop;
  logic            empty;
  jsu_pkg::burst_t head;

  // byte decoder
  jsu_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .end_of_string_i (end_of_string_i),
    .fifo_full_i     (full),
    .push_o          (push),
    .burst_o         (push_data)
  );

  // unit group queue
  jsu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  // unit serializer
  jsu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_unit_o   (code_unit_o),
    .run_last_o    (run_last_o),
    .string_last_o (string_last_o)
  );

endmodule

FILE: rtl/core/jsu_fifo.sv
module jsu_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  jsu_pkg::burst_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output jsu_pkg::burst_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  jsu_pkg::burst_t    mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/core/jsu_front.sv
module jsu_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      data_byte_i,
  input  logic            end_of_string_i,
  input  logic            fifo_full_i,
  output logic            push_o,
  output jsu_pkg::burst_t burst_o
);

  jsu_pkg::mode_e mode_q, mode_d;
  logic [1:0]     exp_q, exp_d;
  logic [1:0]     buf_q, buf_d;
  logic [20:0]    acc_q, acc_d;
  logic [2:0]     hcnt_q, hcnt_d;

  logic [jsu_pkg::NUM_UNITS-1:0][15:0] units;
  logic [2:0]     n;
  logic           do_plain;
  logic           accept;
  logic [7:0]     b;
  logic           eos;
  logic [15:0]    hex16;
  logic [20:0]    cont_acc;
  logic [20:0]    supp;
  logic [1:0]     buf_inc;
  logic [1:0]     repl_last;
  logic [1:0]     lead_extra;
  logic [20:0]    lead_acc;
  logic           is_lead;

  // ascii hex digit value, anything else counts as zero
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= jsu_pkg::CHAR_0 && c <= jsu_pkg::CHAR_9) begin
      v = 4'(c - jsu_pkg::CHAR_0);
    end else if (c >= jsu_pkg::CHAR_LA && c <= jsu_pkg::CHAR_LF) begin
      v = 4'(c - jsu_pkg::CHAR_LA + 8'd10);
    end else if (c >= jsu_pkg::CHAR_UA && c <= jsu_pkg::CHAR_UF) begin
      v = 4'(c - jsu_pkg::CHAR_UA + 8'd10);
    end
    return v;
  endfunction

  assign b          = data_byte_i;
  assign eos        = end_of_string_i;
  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign hex16      = {acc_q[11:0], hex_val(b)};
  assign cont_acc   = {acc_q[14:0], b[5:0]};
  assign supp       = cont_acc - jsu_pkg::SUPP_BASE;
  assign buf_inc    = buf_q + 2'd1;

  // byte decode: next state and the units this byte produces
  always_comb begin
    mode_d     = mode_q;
    exp_d      = exp_q;
    buf_d      = buf_q;
    acc_d      = acc_q;
    hcnt_d     = hcnt_q;
    units      = '0;
    n          = 3'd0;
    do_plain   = 1'b0;
    repl_last  = 2'd0;
    lead_extra = 2'd0;
    lead_acc   = '0;
    is_lead    = 1'b0;

    unique case (mode_q)
      jsu_pkg::MODE_ESC: begin
        mode_d = jsu_pkg::MODE_PLAIN;
        unique case (b)
          jsu_pkg::CHAR_N:      begin units[0] = jsu_pkg::CODE_LF;  n = 3'd1; end
          jsu_pkg::CHAR_T:      begin units[0] = jsu_pkg::CODE_TAB; n = 3'd1; end
          jsu_pkg::CHAR_R:      begin units[0] = jsu_pkg::CODE_CR;  n = 3'd1; end
          jsu_pkg::CHAR_B:      begin units[0] = jsu_pkg::CODE_BS;  n = 3'd1; end
          jsu_pkg::CHAR_F:      begin units[0] = jsu_pkg::CODE_FF;  n = 3'd1; end
          jsu_pkg::CHAR_U: begin
            if (eos) begin
              units[0] = '0;
              n        = 3'd1;
            end else begin
              mode_d = jsu_pkg::MODE_HEX;
              acc_d  = '0;
              hcnt_d = '0;
            end
          end
          default: begin
            // quote, backslash, slash and unknown escapes pass the byte
            units[0] = {8'h00, b};
            n        = 3'd1;
          end
        endcase
      end

      jsu_pkg::MODE_HEX: begin
        acc_d  = {5'd0, hex16};
        hcnt_d = hcnt_q + 3'd1;
        if (hcnt_d >= 3'd4 || eos) begin
          units[0] = hex16;
          n        = 3'd1;
          mode_d   = jsu_pkg::MODE_PLAIN;
        end
      end

      jsu_pkg::MODE_UTF8: begin
        if (b[7:6] == 2'b10) begin
          acc_d = cont_acc;
          buf_d = buf_inc;
          if (buf_inc >= exp_q) begin
            // complete code point, split into a surrogate pair if needed
            if (cont_acc <= jsu_pkg::BMP_MAX) begin
              units[0] = cont_acc[15:0];
              n        = 3'd1;
            end else begin
              units[0] = jsu_pkg::HI_SURR + {5'd0, supp[20:10]};
              units[1] = jsu_pkg::LO_SURR + {6'd0, supp[9:0]};
              n        = 3'd2;
            end
            mode_d = jsu_pkg::MODE_PLAIN;
          end else if (eos) begin
            repl_last = buf_inc;
            for (int k = 0; k < 4; k++) begin
              if (k <= int'(repl_last)) begin
                units[n[1:0]] = jsu_pkg::REPL_CHAR;
                n             = n + 3'd1;
              end
            end
            mode_d = jsu_pkg::MODE_PLAIN;
          end
        end else begin
          // broken sequence: one replacement per buffered byte, then redo the byte
          repl_last = buf_q;
          for (int k = 0; k < 4; k++) begin
            if (k <= int'(repl_last)) begin
              units[n[1:0]] = jsu_pkg::REPL_CHAR;
              n             = n + 3'd1;
            end
          end
          buf_d    = '0;
          do_plain = 1'b1;
        end
      end

      jsu_pkg::MODE_PLAIN: begin
        do_plain = 1'b1;
      end

      default: begin
        do_plain = 1'b1;
      end
    endcase

    // plain text byte handling
    if (do_plain) begin
      mode_d = jsu_pkg::MODE_PLAIN;
      if (b == jsu_pkg::CHAR_BSLASH) begin
        if (eos) begin
          units[n[1:0]] = {8'h00, b};
          n             = n + 3'd1;
        end else begin
          mode_d = jsu_pkg::MODE_ESC;
        end
      end else if (!b[7]) begin
        units[n[1:0]] = {8'h00, b};
        n             = n + 3'd1;
      end else if (b[7:5] == 3'b110) begin
        is_lead    = 1'b1;
        lead_acc   = {16'd0, b[4:0]};
        lead_extra = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        is_lead    = 1'b1;
        lead_acc   = {17'd0, b[3:0]};
        lead_extra = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        is_lead    = 1'b1;
        lead_acc   = {18'd0, b[2:0]};
        lead_extra = 2'd3;
      end else begin
        units[n[1:0]] = jsu_pkg::REPL_CHAR;
        n             = n + 3'd1;
      end
      if (is_lead) begin
        if (eos) begin
          units[n[1:0]] = jsu_pkg::REPL_CHAR;
          n             = n + 3'd1;
        end else begin
          acc_d  = lead_acc;
          exp_d  = lead_extra;
          buf_d  = '0;
          mode_d = jsu_pkg::MODE_UTF8;
        end
      end
    end

    // end of string returns everything to its reset value
    if (eos) begin
      mode_d = jsu_pkg::MODE_PLAIN;
      exp_d  = '0;
      buf_d  = '0;
      acc_d  = '0;
      hcnt_d = '0;
    end
  end

  assign push_o            = accept && (n != 3'd0);
  assign burst_o.last_idx  = 2'(n - 3'd1);
  assign burst_o.eos       = eos;
  assign burst_o.units     = units;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsu_pkg::MODE_PLAIN;
      exp_q  <= '0;
      buf_q  <= '0;
      acc_q  <= '0;
      hcnt_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      exp_q  <= exp_d;
      buf_q  <= buf_d;
      acc_q  <= acc_d;
      hcnt_q <= hcnt_d;
    end
  end

endmodule

FILE: rtl/core/jsu_back.sv
module jsu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  jsu_pkg::burst_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [15:0]     code_unit_o,
  output logic            run_last_o,
  output logic            string_last_o
);

  logic        valid_q, valid_d;
  logic [1:0]  idx_q, idx_d;
  logic [15:0] unit_q;
  logic        run_last_q;
  logic        string_last_q;
  logic        load;
  logic        is_last;

  assign load    = !empty_i && (!valid_q || out_ready_i);
  assign is_last = (idx_q == head_i.last_idx);
  assign pop_o   = load && is_last;

  // walk the head word one unit per cycle while the output register can load
  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = is_last ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      unit_q        <= head_i.units[idx_q];
      run_last_q    <= is_last;
      string_last_q <= is_last && head_i.eos;
    end
  end

  assign out_valid_o   = valid_q;
  assign code_unit_o   = unit_q;
  assign run_last_o    = run_last_q;
  assign string_last_o = string_last_q;

endmodule

FILE: dv/tb_json_string_utf8_to_utf16.sv
`timescale 1ns / 1ps

module tb_json_string_utf8_to_utf16;

  localparam int unsigned RandBytes  = 480;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned DirRows    = 27;

  // one code unit as it leaves the block
  typedef struct packed {
    logic [15:0] code;
    logic        run_last;
    logic        string_last;
  } unit_t;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_PRED,
    CHK_NONE,
    CHK_ONE
  } row_chk_e;

  typedef struct packed {
    logic [7:0]  data;
    logic        eos;
    row_chk_e    chk;
    logic [15:0] code;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        end_of_string_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] code_unit_o;
  logic        run_last_o;
  logic        string_last_o;

  json_string_utf8_to_utf16 i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_string_i(end_of_string_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .code_unit_o    (code_unit_o),
    .run_last_o     (run_last_o),
    .string_last_o  (string_last_o)
  );

  // decoder state mirrored by the predictor
  jsu_pkg::mode_e dec_mode = jsu_pkg::MODE_PLAIN;
  logic [1:0]  seq_len = '0;
  logic [1:0]  seq_got = '0;
  logic [20:0] cp_acc = '0;
  logic [2:0]  hex_cnt = '0;

  logic [15:0] byte_units[$];
  unit_t       units_due[$];
  logic [7:0]  str_bytes[$];

  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit          send_quiet = 1'b0;
  bit          recv_quiet = 1'b0;

  logic [7:0] esc_chars [8] = '{jsu_pkg::CHAR_N, jsu_pkg::CHAR_T, jsu_pkg::CHAR_R,
                                jsu_pkg::CHAR_B, jsu_pkg::CHAR_F, jsu_pkg::CHAR_QUOTE,
                                jsu_pkg::CHAR_BSLASH, jsu_pkg::CHAR_SLASH};

  // directed strings: extremes, escapes, \u edge cases, utf-8 sequences and breakage
  dir_row_t dir_rows [DirRows] = '{
    '{8'h00,                1'b0, CHK_ONE,  16'h0000},
    '{8'hFF,                1'b0, CHK_ONE,  jsu_pkg::REPL_CHAR},
    '{jsu_pkg::CHAR_BSLASH, 1'b0, CHK_NONE, 16'h0000},
    '{jsu_pkg::CHAR_N,      1'b0, CHK_ONE,  jsu_pkg::CODE_LF},
    '{jsu_pkg::CHAR_BSLASH, 1'b0, CHK_NONE, 16'h0000},
    '{8'h71,                1'b0, CHK_ONE,  16'h0071},
    '{jsu_pkg::CHAR_BSLASH, 1'b0, CHK_NONE, 16'h0000},
    '{jsu_pkg::CHAR_U,      1'b0, CHK_NONE, 16'h0000},
    '{jsu_pkg::CHAR_UF,     1'b0, CHK_PRED, 16'h0000},
    '{8'h7A,                1'b1, CHK_PRED, 16'h0000},
    '{8'hF0,                1'b0, CHK_PRED, 16'h0000},
    '{8'h9F,                1'b0, CHK_PRED, 16'h0000},
    '{8'h98,                1'b0, CHK_PRED, 16'h0000},
    '{8'h80,                1'b0, CHK_PRED, 16'h0000},
    '{8'hE2,                1'b0, CHK_PRED, 16'h0000},
    '{8'h82,                1'b0, CHK_PRED, 16'h0000},
    '{8'h41,                1'b0, CHK_PRED, 16'h0000},
    '{8'hF7,                1'b0, CHK_PRED, 16'h0000},
    '{8'hBF,                1'b0, CHK_PRED, 16'h0000},
    '{8'hBF,                1'b0, CHK_PRED, 16'h0000},
    '{8'hBF,                1'b1, CHK_PRED, 16'h0000},
    '{8'hC3,                1'b1, CHK_ONE,  jsu_pkg::REPL_CHAR},
    '{jsu_pkg::CHAR_BSLASH, 1'b1, CHK_ONE,  16'h005C},
    '{jsu_pkg::CHAR_BSLASH, 1'b0, CHK_NONE, 16'h0000},
    '{jsu_pkg::CHAR_U,      1'b1, CHK_ONE,  16'h0000},
    '{8'hE2,                1'b0, CHK_PRED, 16'h0000},
    '{8'h82,                1'b1, CHK_PRED, 16'h0000}
  };

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- queues

  function void add_str_byte(input logic [7:0] b);
    str_bytes.insert(str_bytes.size(), b);
  endfunction

  function void add_due(input unit_t u);
    units_due.insert(units_due.size(), u);
  endfunction

  // ---------------------------------------------------------------- predictor

  function void put_unit(input logic [15:0] code);
    if (byte_units.size() < 4) byte_units.insert(byte_units.size(), code);
  endfunction

  // supplementary code points split into a surrogate pair
  function void put_code_point(input logic [20:0] cp);
    logic [20:0] off;
    if (cp <= jsu_pkg::BMP_MAX) begin
      put_unit(cp[15:0]);
    end else begin
      off = cp - jsu_pkg::SUPP_BASE;
      put_unit(jsu_pkg::HI_SURR + {5'd0, off[20:10]});
      put_unit(jsu_pkg::LO_SURR + {6'd0, off[9:0]});
    end
  endfunction

  // anything that is not a hex digit counts as zero
  function logic [3:0] nibble_of(input logic [7:0] b);
    if (b >= jsu_pkg::CHAR_0 && b <= jsu_pkg::CHAR_9) return 4'(b - jsu_pkg::CHAR_0);
    if (b >= jsu_pkg::CHAR_LA && b <= jsu_pkg::CHAR_LF) begin
      return 4'(b - jsu_pkg::CHAR_LA + 8'd10);
    end
    if (b >= jsu_pkg::CHAR_UA && b <= jsu_pkg::CHAR_UF) begin
      return 4'(b - jsu_pkg::CHAR_UA + 8'd10);
    end
    return 4'h0;
  endfunction

  // byte seen outside any escape or sequence
  function void take_plain(input logic [7:0] b, input logic eos);
    logic [1:0] extra;
    dec_mode = jsu_pkg::MODE_PLAIN;
    if (b == jsu_pkg::CHAR_BSLASH) begin
      if (eos) put_unit({8'h00, b});
      else dec_mode = jsu_pkg::MODE_ESC;
      return;
    end
    if (!b[7]) begin
      put_unit({8'h00, b});
      return;
    end
    if (b[7:5] == 3'b110) begin
      cp_acc = {16'd0, b[4:0]};
      extra = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      cp_acc = {17'd0, b[3:0]};
      extra = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      cp_acc = {18'd0, b[2:0]};
      extra = 2'd3;
    end else begin
      put_unit(jsu_pkg::REPL_CHAR);
      return;
    end
    // lead byte that ends the string
    if (eos) begin
      put_unit(jsu_pkg::REPL_CHAR);
      cp_acc = '0;
      return;
    end
    seq_len  = extra;
    seq_got  = 2'd0;
    dec_mode = jsu_pkg::MODE_UTF8;
  endfunction

  // byte after a backslash
  function void take_escape(input logic [7:0] b, input logic eos);
    dec_mode = jsu_pkg::MODE_PLAIN;
    case (b)
      jsu_pkg::CHAR_N: put_unit(jsu_pkg::CODE_LF);
      jsu_pkg::CHAR_T: put_unit(jsu_pkg::CODE_TAB);
      jsu_pkg::CHAR_R: put_unit(jsu_pkg::CODE_CR);
      jsu_pkg::CHAR_B: put_unit(jsu_pkg::CODE_BS);
      jsu_pkg::CHAR_F: put_unit(jsu_pkg::CODE_FF);
      jsu_pkg::CHAR_U: begin
        if (eos) begin
          put_unit(16'h0000);
        end else begin
          dec_mode = jsu_pkg::MODE_HEX;
          cp_acc   = '0;
          hex_cnt  = '0;
        end
      end
      // quote, backslash, slash and unknown escapes all give the byte itself
      default: put_unit({8'h00, b});
    endcase
  endfunction

  // units caused by one byte land in byte_units
  function void decode_byte(input logic [7:0] b, input logic eos);
    int k;
    byte_units.delete();
    case (dec_mode)
      jsu_pkg::MODE_ESC: take_escape(b, eos);
      jsu_pkg::MODE_HEX: begin
        cp_acc  = {5'd0, cp_acc[11:0], nibble_of(b)};
        hex_cnt = hex_cnt + 3'd1;
        if (hex_cnt >= 3'd4 || eos) begin
          put_unit(cp_acc[15:0]);
          dec_mode = jsu_pkg::MODE_PLAIN;
        end
      end
      jsu_pkg::MODE_UTF8: begin
        if (b[7:6] == 2'b10) begin
          cp_acc  = {cp_acc[14:0], b[5:0]};
          seq_got = seq_got + 2'd1;
          if (seq_got >= seq_len) begin
            put_code_point(cp_acc);
            dec_mode = jsu_pkg::MODE_PLAIN;
          end else if (eos) begin
            for (k = 0; k <= int'(seq_got); k++) put_unit(jsu_pkg::REPL_CHAR);
            dec_mode = jsu_pkg::MODE_PLAIN;
          end
        end else begin
          // broken sequence: one replacement per buffered byte, then start over
          for (k = 0; k <= int'(seq_got); k++) put_unit(jsu_pkg::REPL_CHAR);
          seq_got = 2'd0;
          take_plain(b, eos);
        end
      end
      default: take_plain(b, eos);
    endcase
    if (eos) begin
      dec_mode = jsu_pkg::MODE_PLAIN;
      seq_len  = '0;
      seq_got  = '0;
      cp_acc   = '0;
      hex_cnt  = '0;
    end
  endfunction

  function void queue_units(input logic eos);
    int last;
    last = byte_units.size() - 1;
    foreach (byte_units[i]) begin
      add_due({byte_units[i], i == last, (i == last) && eos});
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function logic [7:0] hex_digit();
    int unsigned v;
    v = $urandom_range(0, 15);
    if (v < 10) return jsu_pkg::CHAR_0 + 8'(v);
    return ($urandom_range(0, 1) ? jsu_pkg::CHAR_UA : jsu_pkg::CHAR_LA) + 8'(v - 10);
  endfunction

  // one piece of a string: mostly well-formed, some broken, some noise
  function void add_token();
    int unsigned pick, n, nc;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      b = 8'($urandom_range(8'h20, 8'h7E));
      add_str_byte(b == jsu_pkg::CHAR_BSLASH ? jsu_pkg::CHAR_QUOTE : b);
    end else if (pick < 45) begin
      add_str_byte(jsu_pkg::CHAR_BSLASH);
      add_str_byte(esc_chars[$urandom_range(0, 7)]);
    end else if (pick < 50) begin
      add_str_byte(jsu_pkg::CHAR_BSLASH);
      add_str_byte(8'($urandom_range(0, 255)));
    end else if (pick < 60) begin
      add_str_byte(jsu_pkg::CHAR_BSLASH);
      add_str_byte(jsu_pkg::CHAR_U);
      repeat (4) begin
        add_str_byte($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255))
                                               : hex_digit());
      end
    end else if (pick < 92) begin
      // utf-8 sequence, cut short from 84 up
      n  = pick < 66 ? 1 : pick < 74 ? 2 : pick < 84 ? 3 : $urandom_range(1, 3);
      nc = pick < 84 ? n : $urandom_range(0, n - 1);
      case (n)
        1:       b = 8'hC0 + 8'($urandom_range(0, 31));
        2:       b = 8'hE0 + 8'($urandom_range(0, 15));
        default: b = 8'hF0 + 8'($urandom_range(0, 7));
      endcase
      add_str_byte(b);
      repeat (nc) add_str_byte(8'h80 + 8'($urandom_range(0, 63)));
    end else begin
      add_str_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  // present one word and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int unsigned gap;
    logic        took;
    gap = send_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    end_of_string_i <= eos;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
  endtask

  initial begin
    int unsigned bytes_sent;
    logic        last;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    foreach (dir_rows[r]) begin
      send_byte(dir_rows[r].data, dir_rows[r].eos);
      decode_byte(dir_rows[r].data, dir_rows[r].eos);
      if (dir_rows[r].chk == CHK_PRED) begin
        queue_units(dir_rows[r].eos);
      end else if (dir_rows[r].chk == CHK_ONE) begin
        add_due({dir_rows[r].code, 1'b1, dir_rows[r].eos});
      end
    end

    // random strings
    bytes_sent = 0;
    while (bytes_sent < RandBytes) begin
      str_bytes.delete();
      repeat ($urandom_range(1, 8)) add_token();
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      foreach (str_bytes[i]) begin
        last = (i == str_bytes.size() - 1);
        send_byte(str_bytes[i], last);
        decode_byte(str_bytes[i], last);
        queue_units(last);
        bytes_sent++;
      end
    end
    in_valid_i <= 1'b0;

    // drain
    while (units_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // ---------------------------------------------------------------- checking

  function void check_unit(input unit_t seen);
    unit_t want;
    if (units_due.size() == 0) begin
      $display("%0t: unit %h arrived with nothing expected", $time, seen.code);
      errors++;
      return;
    end
    want = units_due.pop_front();
    if (seen.code !== want.code) begin
      $display("%0t: code_unit expected %h got %h", $time, want.code, seen.code);
      errors++;
    end
    if (seen.run_last !== want.run_last) begin
      $display("%0t: run_last expected %b got %b", $time, want.run_last, seen.run_last);
      errors++;
    end
    if (seen.string_last !== want.string_last) begin
      $display("%0t: string_last expected %b got %b", $time, want.string_last,
               seen.string_last);
      errors++;
    end
  endfunction

  // receiver with random back-pressure
  initial begin
    int unsigned stall;
    logic        got;
    unit_t       seen;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = recv_quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        got  = out_valid_o;
        seen = {code_unit_o, run_last_o, string_last_o};
        @(posedge clk_i);
      end while (!got);
      check_unit(seen);
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    forever begin
      @(negedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
